FILE: design/lod_pkg.sv
// lod_pkg: shared constants, types and tables of the luminance ordered dither
// used by the interfaces, the channel divider and the top level
package lod_pkg;

    // field widths
    localparam int PIX_W   = 32;
    localparam int POS_W   = 12;
    localparam int STR_W   = 16;
    localparam int LEV_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // internal widths
    localparam int SUM_W  = 24;  // weighted channel sum before division by 255
    localparam int LUM_W  = 17;  // luminance, q1.16, 0..65536
    localparam int DIT_W  = 18;  // dithered value, q.17, 0..131072
    localparam int PROD_W = 17;  // channel times level
    localparam int DEN_W  = 26;  // levels times luminance
    localparam int REM_W  = 33;  // numerator, product shifted by 16

    // channel divider: 8 quotient bits, one a stage, plus a saturation stage
    localparam int DIV_STEPS = 8;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    // positions at or beyond this are passed through untouched
    localparam logic [16:0] CANVAS_MAX = 17'd4096;

    // luminance weights in q16, rounding offset and reciprocal of 255 (2^32 scale)
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;
    localparam logic [7:0]  LUM_ROUND = 8'd127;
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    // luminance at or below this is treated as black
    localparam logic [LUM_W-1:0] DARK_MAX = 17'd6;

    // full scale of the dithered value
    localparam logic [DIT_W-1:0] DIT_ONE = 18'd131072;

    // register reset values
    localparam logic [STR_W-1:0] STRENGTH_RST = 16'd4096;
    localparam logic [LEV_W-1:0] LEVELS_RST   = 9'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRENGTH = 2'd0,
        CFG_LEVELS   = 2'd1
    } t_cfg_idx;

    // 4x4 bayer matrix, indexed by {y[1:0], x[1:0]}
    localparam logic [3:0] BAYER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

endpackage

FILE: design/lod_if.sv
// lod_if: valid/ready channel interfaces for pixel input, pixel output
// and configuration writes; depends on lod_pkg for widths
interface lod_in_if;
    import lod_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    modport source (output valid, output pixel_in, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pixel_in, input pos_x, input pos_y, output ready);
endinterface

interface lod_out_if;
    import lod_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

interface lod_cfg_if;
    import lod_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/lod_div.sv
// lod_div: pipelined restoring divider for one colour channel,
// min(255, floor(prod * 65536 / den)); depends on lod_pkg
module lod_div import lod_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PROD_W-1:0] i_prod,
    input  logic [DEN_W-1:0]  i_den,
    output logic [7:0]        o_quo
);

    logic [REM_W-1:0] r_rem [0:DIV_STEPS];
    logic [DEN_W-1:0] r_den [0:DIV_STEPS];
    logic [7:0]       r_quo [0:DIV_STEPS];
    logic             r_sat [0:DIV_STEPS];

    // entry stage: quotient of 256 or more saturates, numerator is prod << 16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= ({1'b0, i_prod, 8'b0} >= i_den);
            r_rem[0] <= {i_prod, 16'b0};
            r_quo[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - s;
        logic [REM_W:0]   trial;
        logic             ge;
        logic [REM_W-1:0] n_rem;
        logic [7:0]       n_quo;

        always_comb begin
            trial = (REM_W+1)'(r_den[s]) << BIT;
            ge    = ({1'b0, r_rem[s]} >= trial);
            n_rem = ge ? (r_rem[s] - trial[REM_W-1:0]) : r_rem[s];
            n_quo = r_quo[s];
            n_quo[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_quo[s+1] <= n_quo;
                r_den[s+1] <= r_den[s];
                r_sat[s+1] <= r_sat[s];
            end
        end
    end

    assign o_quo = r_sat[DIV_STEPS] ? 8'hFF : r_quo[DIV_STEPS];

endmodule

FILE: design/luminance_ordered_dither_core.sv
// luminance_ordered_dither_core: 4x4 bayer ordered dither on pixel luminance
// depends on lod_pkg, lod_if and lod_div
//
// usage:
//   i_pix carries one packed pixel (red, green, blue, alpha bytes) with its
//   column and row; o_pix returns the dithered pixel, alpha unchanged.
//   i_cfg writes the threshold strength (index 0, q4.12) and the level count
//   (index 1); other indexes are ignored. writes are always taken (ready high)
//   and belong only to times when no item is in flight.
//   one item per cycle is sustained while o_pix is taken. the depth from
//   acceptance to o_pix.valid is set by the luminance, dither and quantize
//   stages (six registers), the per-channel divider (a saturation entry stage
//   and one bit per stage after it, nine stages) and the output register.
//   the pipeline moves as a whole: when o_pix holds a result that is not
//   taken, every stage holds and i_pix.ready drops; nothing is lost or
//   repeated. empty slots travel as bubbles.
//   synchronous reset clears all valid bits and sets the strength to
//   1.0 and the level count to 2.
module luminance_ordered_dither_core import lod_pkg::*; #(
    parameter logic [16:0] CANVAS_LIMIT = CANVAS_MAX
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lod_in_if.sink    i_pix,
    lod_cfg_if.sink   i_cfg,
    lod_out_if.source o_pix
);

    // configuration registers
    logic [STR_W-1:0] r_strength;
    logic [LEV_W-1:0] r_levels;
    logic [LEV_W-1:0] lv;

    // pipeline control
    logic en;
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic r_dvld [0:DIV_LAT-1];
    logic r_out_vld;

    // payload registers
    logic [PIX_W-1:0] r1_pix, r2_pix, r3_pix, r4_pix, r5_pix, r6_pix;
    logic [POS_W-1:0] r1_x, r1_y;
    logic             r2_byp, r3_byp, r4_byp, r5_byp, r6_byp;
    logic [3:0]       r2_k, r3_k;
    logic [SUM_W-1:0] r2_sum;
    logic [LUM_W-1:0] r3_lum;
    logic [DIT_W-1:0] r4_d;
    logic [DEN_W-1:0] r4_den, r5_den, r6_den;
    logic             r4_dark, r5_dark, r6_dark;
    logic [LEV_W-1:0] r5_q;
    logic [PROD_W-1:0] r6_pr, r6_pg, r6_pb;
    logic [PIX_W-1:0] r_dpix  [0:DIV_LAT-1];
    logic             r_dbyp  [0:DIV_LAT-1];
    logic             r_ddark [0:DIV_LAT-1];
    logic [PIX_W-1:0] r_out_pix;

    // combinational stage values
    logic [SUM_W-1:0]   s_sum;
    logic [48:0]        s_lum_prod;
    logic signed [5:0]  s_thr;
    logic signed [22:0] s_scaled;
    logic signed [22:0] s_dsum;
    logic [DIT_W-1:0]   s_d;
    logic [DEN_W-1:0]   s_den;
    logic [26:0]        s_qprod;
    logic [7:0]         qr, qg, qb;
    logic [PIX_W-1:0]   n_out_pix;

    // whole pipeline advances unless the output holds an untaken item
    assign en = !r_out_vld || o_pix.ready;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;
    assign lv = (r_levels == '0) ? 9'd1 : r_levels;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= STRENGTH_RST;
            r_levels   <= LEVELS_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_STRENGTH: r_strength <= i_cfg.data;
                CFG_LEVELS:   r_levels   <= i_cfg.data[LEV_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) r_dvld[i] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pix.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r_dvld[0] <= r6_vld;
            for (int i = 1; i < DIV_LAT; i++) r_dvld[i] <= r_dvld[i-1];
            r_out_vld <= r_dvld[DIV_LAT-1];
        end
    end

    // stage values
    always_comb begin
        // weighted sum with rounding for the divide by 255
        s_sum = SUM_W'(COEF_R) * SUM_W'(r1_pix[7:0])
              + SUM_W'(COEF_G) * SUM_W'(r1_pix[15:8])
              + SUM_W'(COEF_B) * SUM_W'(r1_pix[23:16])
              + SUM_W'(LUM_ROUND);
        // divide by 255 through the reciprocal, exact below 2^24
        s_lum_prod = 49'(r2_sum) * 49'(RECIP_255);
        // threshold 2k-15 scaled by strength, added to twice the luminance
        s_thr    = $signed({1'b0, r3_k, 1'b0}) - 6'sd15;
        s_scaled = $signed({{17{s_thr[5]}}, s_thr}) * $signed({7'b0, r_strength});
        s_dsum   = s_scaled + $signed({5'b0, r3_lum, 1'b0});
        if (s_dsum < 0) begin
            s_d = '0;
        end else if (s_dsum > $signed({5'b0, DIT_ONE})) begin
            s_d = DIT_ONE;
        end else begin
            s_d = s_dsum[DIT_W-1:0];
        end
        s_den = DEN_W'(r3_lum) * DEN_W'(lv);
        // quantized level
        s_qprod = 27'(r4_d) * 27'(lv);
    end

    // front stages: sum, luminance, dither, level, channel products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pix <= i_pix.pixel_in;
            r1_x   <= i_pix.pos_x;
            r1_y   <= i_pix.pos_y;

            r2_pix <= r1_pix;
            r2_sum <= s_sum;
            r2_k   <= BAYER[{r1_y[1:0], r1_x[1:0]}];
            r2_byp <= ({5'b0, r1_x} >= CANVAS_LIMIT) || ({5'b0, r1_y} >= CANVAS_LIMIT);

            r3_pix <= r2_pix;
            r3_byp <= r2_byp;
            r3_k   <= r2_k;
            r3_lum <= s_lum_prod[48:32];

            r4_pix  <= r3_pix;
            r4_byp  <= r3_byp;
            r4_d    <= s_d;
            r4_den  <= s_den;
            r4_dark <= (r3_lum <= DARK_MAX);

            r5_pix  <= r4_pix;
            r5_byp  <= r4_byp;
            r5_den  <= r4_den;
            r5_dark <= r4_dark;
            r5_q    <= s_qprod[25:17];

            r6_pix  <= r5_pix;
            r6_byp  <= r5_byp;
            r6_den  <= r5_den;
            r6_dark <= r5_dark;
            r6_pr   <= PROD_W'(r5_pix[7:0])   * PROD_W'(r5_q);
            r6_pg   <= PROD_W'(r5_pix[15:8])  * PROD_W'(r5_q);
            r6_pb   <= PROD_W'(r5_pix[23:16]) * PROD_W'(r5_q);
        end
    end

    // per-channel dividers
    lod_div u_div_r (.i_clk(i_clk), .i_en(en), .i_prod(r6_pr), .i_den(r6_den), .o_quo(qr));
    lod_div u_div_g (.i_clk(i_clk), .i_en(en), .i_prod(r6_pg), .i_den(r6_den), .o_quo(qg));
    lod_div u_div_b (.i_clk(i_clk), .i_en(en), .i_prod(r6_pb), .i_den(r6_den), .o_quo(qb));

    // side line carrying pixel and flags alongside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dpix[0]  <= r6_pix;
            r_dbyp[0]  <= r6_byp;
            r_ddark[0] <= r6_dark;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dpix[i]  <= r_dpix[i-1];
                r_dbyp[i]  <= r_dbyp[i-1];
                r_ddark[i] <= r_ddark[i-1];
            end
        end
    end

    // output pixel: bypass, black, or scaled channels
    always_comb begin
        if (r_dbyp[DIV_LAT-1]) begin
            n_out_pix = r_dpix[DIV_LAT-1];
        end else if (r_ddark[DIV_LAT-1]) begin
            n_out_pix = {r_dpix[DIV_LAT-1][31:24], 24'b0};
        end else begin
            n_out_pix = {r_dpix[DIV_LAT-1][31:24], qb, qg, qr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pix <= n_out_pix;
        end
    end

    assign o_pix.valid     = r_out_vld;
    assign o_pix.pixel_out = r_out_pix;

endmodule

FILE: verif/luminance_ordered_dither_core_tb.sv
// luminance_ordered_dither_core_tb: self-checking bench for the bayer luminance dither
// predicts every output pixel and compares it across register settings and idle patterns
// depends on lod_pkg, lod_if and the luminance_ordered_dither_core rtl
module luminance_ordered_dither_core_tb;
    import lod_pkg::*;

    // bench limits
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASE_ITEMS    = 110;

    // register values after reset
    localparam logic [15:0] STRENGTH_AT_RESET = 16'd4096;
    localparam logic [8:0]  LEVELS_AT_RESET   = 9'd2;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // bayer ranks, row-major over {y mod 4, x mod 4}
    localparam int unsigned BAYER_RANK [16] = '{
        0, 8, 2, 10,
        12, 4, 14, 6,
        3, 11, 1, 9,
        15, 7, 13, 5
    };

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_pixel_item;

    logic i_clk;
    logic i_rst_n;

    lod_in_if  pix_if ();
    lod_cfg_if cfg_if ();
    lod_out_if out_if ();

    luminance_ordered_dither_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_pix   (out_if)
    );

    t_pixel_item      pending [$];
    logic [PIX_W-1:0] expected_pixels [$];
    logic [15:0]      model_strength;
    logic [8:0]       model_levels;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               fail_count;
    int               idle_cycles;
    bit               in_taken;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected output pixel for the current register settings
    function automatic logic [PIX_W-1:0] dither_pixel(logic [PIX_W-1:0] pix,
                                                      logic [POS_W-1:0] px,
                                                      logic [POS_W-1:0] py);
        logic [7:0]        ch  [3];
        logic [7:0]        res [3];
        longint unsigned   lum;
        longint unsigned   lv;
        longint unsigned   qlev;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   v;
        longint            d;
        int                k;
        ch[0] = pix[7:0];
        ch[1] = pix[15:8];
        ch[2] = pix[23:16];
        // off-canvas pixels pass through untouched
        if (({5'b0, px} >= CANVAS_MAX) || ({5'b0, py} >= CANVAS_MAX))
            return pix;
        lum = (64'd19595 * longint'(ch[0]) + 64'd38470 * longint'(ch[1])
               + 64'd7471 * longint'(ch[2]) + 64'd127) / 64'd255;
        k = BAYER_RANK[{py[1:0], px[1:0]}];
        d = 2 * longint'(lum) + longint'(2 * k - 15) * longint'(model_strength);
        if (d < 0) d = 0;
        if (d > 131072) d = 131072;
        lv = (model_levels == 9'd0) ? 64'd1 : longint'(model_levels);
        qlev = (longint'(d) * lv) >> 17;
        for (int i = 0; i < 3; i++) begin
            if (lum <= 6) begin
                // dark pixel goes to black
                res[i] = 8'd0;
            end else begin
                num = longint'(ch[i]) * qlev * 64'd65536;
                den = lv * lum;
                v = num / den;
                res[i] = (v > 255) ? 8'd255 : v[7:0];
            end
        end
        return {pix[31:24], res[2], res[1], res[0]};
    endfunction

    // pixel with a bias toward dark, grey and saturated colors
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom;
        case ($urandom_range(9))
            0: p[23:0] = 24'd0;
            1: begin
                p[15:8]  = p[7:0];
                p[23:16] = p[7:0];
            end
            2: begin
                p[7:0]   = {8{p[0]}};
                p[15:8]  = {8{p[1]}};
                p[23:16] = {8{p[2]}};
            end
            3: p[23:0] = p[23:0] & 24'h070707;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [POS_W-1:0] random_pos();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? {POS_W{1'b1}} : {POS_W{1'b0}};
        return POS_W'($urandom_range((1 << POS_W) - 1));
    endfunction

    // pixel driver, fed from the pending queue
    always @(negedge i_clk) begin : drive_pixels
        t_pixel_item next;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || in_taken) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next = pending.pop_front();
                pix_if.valid    <= 1'b1;
                pix_if.pixel_in <= next.pixel;
                pix_if.pos_x    <= next.x;
                pix_if.pos_y    <= next.y;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input, check on output, watchdog
    always @(posedge i_clk) begin : watch_ports
        logic [PIX_W-1:0] want;
        in_taken = i_rst_n && pix_if.valid && pix_if.ready;
        if (i_rst_n) begin
            if (in_taken)
                expected_pixels.push_back(dither_pixel(pix_if.pixel_in, pix_if.pos_x,
                                                       pix_if.pos_y));
            if (out_if.valid && out_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out %h arrived with no item outstanding", out_if.pixel_out);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_if.pixel_out !== want) begin
                        $error("pixel_out mismatch: expected %h, got %h",
                               want, out_if.pixel_out);
                        fail_count++;
                    end
                end
            end
            if (in_taken || (out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one register write, mirrored into the predictor
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_STRENGTH)
            model_strength = value;
        else if (idx == CFG_LEVELS)
            model_levels = value[8:0];
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // hold until every queued item is through and answered
    task automatic wait_drained();
        while (pending.size() != 0 || pix_if.valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input logic [PIX_W-1:0] pix, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y);
        t_pixel_item it;
        it.pixel = pix;
        it.x     = x;
        it.y     = y;
        pending.push_back(it);
    endtask

    // reprogram while idle, then stream random items under one idle pattern
    task automatic run_setting(input logic [15:0] strength, input logic [15:0] levels_data,
                               input int idle_pct, input int stall_pct);
        write_register(CFG_STRENGTH, strength);
        write_register(CFG_LEVELS, levels_data);
        if ($urandom_range(1))
            write_register($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                           CFG_DATA_W'($urandom));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
            push_item(random_pixel(), random_pos(), random_pos());
        wait_drained();
    endtask

    // stimulus
    initial begin
        i_rst_n         = 1'b0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        pix_if.pos_x    = '0;
        pix_if.pos_y    = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_STRENGTH;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        model_strength  = STRENGTH_AT_RESET;
        model_levels    = LEVELS_AT_RESET;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        fail_count      = 0;
        idle_cycles     = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset settings
        push_item(32'h00000000, 12'd0, 12'd0);
        push_item(32'hFF000000, 12'd0, 12'd0);
        push_item(32'hFFFFFFFF, 12'd4095, 12'd4095);
        push_item(32'h00FFFFFF, 12'd4095, 12'd0);
        push_item(32'h000000FF, 12'd0, 12'd4095);
        push_item(32'h5A00FF00, 12'd1, 12'd2);
        push_item(32'hA5FF0000, 12'd2, 12'd3);
        push_item(32'h01010101, 12'd3, 12'd1);
        // every threshold cell with a mid grey
        for (int i = 0; i < 16; i++)
            push_item(32'h80808080, POS_W'(i % 4 + 4 * i), POS_W'(i / 4 + 8 * i));
        wait_drained();

        // random items across register extremes and idle patterns
        run_setting(16'd0, 16'd1, 0, 0);
        run_setting(16'hFFFF, 16'd256, 72, 0);
        run_setting(16'd4096, 16'd0, 0, 72);
        run_setting(16'd1024, 16'hFFFF, 33, 33);
        run_setting(16'($urandom), 16'd257, 0, 0);
        run_setting(16'd8192, 16'd4, 72, 0);
        run_setting(16'($urandom_range(16'hFFFF)), 16'($urandom_range(256, 1)), 0, 72);
        run_setting(16'($urandom), 16'($urandom), 33, 33);

        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/lod_pkg.sv
design/lod_if.sv
design/lod_div.sv
design/luminance_ordered_dither_core.sv
verif/luminance_ordered_dither_core_tb.sv
